[rtl/core/mc_tri_pkg.sv]
// Shared types, register indexes, corner/edge geometry and the case table of the triangulator.
package mc_tri_pkg;

  // One grid cell as it arrives on the input channel.
  typedef struct packed {
    logic [7:0]         cell_x;
    logic [7:0]         cell_y;
    logic [7:0]         cell_z;
    logic signed [15:0] value_c0;
    logic signed [15:0] value_c1;
    logic signed [15:0] value_c2;
    logic signed [15:0] value_c3;
    logic signed [15:0] value_c4;
    logic signed [15:0] value_c5;
    logic signed [15:0] value_c6;
    logic signed [15:0] value_c7;
  } mc_in_t;

  // One triangle as it leaves on the result channel.
  typedef struct packed {
    logic [15:0] p0_x;
    logic [15:0] p0_y;
    logic [15:0] p0_z;
    logic [15:0] p1_x;
    logic [15:0] p1_y;
    logic [15:0] p1_z;
    logic [15:0] p2_x;
    logic [15:0] p2_y;
    logic [15:0] p2_z;
    logic [7:0]  cube_case;
    logic        last_triangle;
  } mc_out_t;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SURFACE_LEVEL = 2'd0;
  localparam logic [1:0] CFG_LINEAR_MODE   = 2'd1;

  // First corner of a cube edge.
  function automatic logic [2:0] edge_corner_a(input logic [3:0] edg);
    logic [2:0] c;
    unique case (edg)
      4'd0:    c = 3'd0;
      4'd1:    c = 3'd1;
      4'd2:    c = 3'd2;
      4'd3:    c = 3'd3;
      4'd4:    c = 3'd4;
      4'd5:    c = 3'd5;
      4'd6:    c = 3'd6;
      4'd7:    c = 3'd7;
      4'd8:    c = 3'd0;
      4'd9:    c = 3'd1;
      4'd10:   c = 3'd2;
      4'd11:   c = 3'd3;
      default: c = 3'd0;
    endcase
    return c;
  endfunction

  // Second corner of a cube edge.
  function automatic logic [2:0] edge_corner_b(input logic [3:0] edg);
    logic [2:0] c;
    unique case (edg)
      4'd0:    c = 3'd1;
      4'd1:    c = 3'd2;
      4'd2:    c = 3'd3;
      4'd3:    c = 3'd0;
      4'd4:    c = 3'd5;
      4'd5:    c = 3'd6;
      4'd6:    c = 3'd7;
      4'd7:    c = 3'd4;
      4'd8:    c = 3'd4;
      4'd9:    c = 3'd5;
      4'd10:   c = 3'd6;
      4'd11:   c = 3'd7;
      default: c = 3'd0;
    endcase
    return c;
  endfunction

  // Corner offset inside the cell as {dx, dy, dz}.
  function automatic logic [2:0] corner_pos(input logic [2:0] c);
    logic [2:0] p;
    unique case (c)
      3'd0:    p = 3'b000;
      3'd1:    p = 3'b100;
      3'd2:    p = 3'b101;
      3'd3:    p = 3'b001;
      3'd4:    p = 3'b010;
      3'd5:    p = 3'b110;
      3'd6:    p = 3'b111;
      3'd7:    p = 3'b011;
      default: p = 3'b000;
    endcase
    return p;
  endfunction

  // Triangle count of a table entry: the entry holds a leading marker nibble of 1
  // above its edge digits, so the marker position gives the digit count.
  function automatic logic [2:0] tri_count(input logic [63:0] ent);
    logic [2:0] n;
    n = 3'd0;
    for (int k = 5; k >= 0; k--) begin
      if (n == 3'd0 && ent[12*k +: 4] != 4'd0 && (ent >> (12*k + 4)) == 64'd0) begin
        n = 3'(k);
      end
    end
    return n;
  endfunction

  // Edge lists per case, one hex digit per edge, first edge leftmost, marker on top.
  localparam logic [63:0] TRI_TBL [256] = '{
    64'h1, 64'h1083, 64'h1019, 64'h1183981, 64'h112a, 64'h108312a, 64'h192a029,
    64'h12832a8a98,
    64'h13b2, 64'h10b28b0, 64'h119023b, 64'h11b219b98b, 64'h13a1ba3, 64'h10a108a8ba,
    64'h13903b9ba9, 64'h198aa8b,
    64'h1478, 64'h1430734, 64'h1019847, 64'h1419471731, 64'h112a847, 64'h134730412a,
    64'h192a902847, 64'h12a9297273794,
    64'h18473b2, 64'h1b47b24204, 64'h190184723b, 64'h147b94b9b2921, 64'h13a13ba784,
    64'h11ba14b1047b4, 64'h14789b09bab03, 64'h147b4b99ba,
    64'h1954, 64'h1954083, 64'h1054150, 64'h1854835315, 64'h112a954, 64'h130812a495,
    64'h152a542402, 64'h12a5325354348,
    64'h195423b, 64'h10b208b495, 64'h105401523b, 64'h121525828b485, 64'h1a3ba13954,
    64'h14950818a18ba, 64'h154050b5bab03, 64'h154858aa8b,
    64'h1978579, 64'h1939953573, 64'h1078017157, 64'h1153357, 64'h1978957a12,
    64'h1a12950530573, 64'h1802825857a52, 64'h12a5253357,
    64'h17987893b2, 64'h195797292027b, 64'h123b018178157, 64'h1b21b17715,
    64'h1958857a13a3b, 64'h15705097b010aba0, 64'h1ba0b03a50807570, 64'h1ba57b5,
    64'h1a65, 64'h10835a6, 64'h19015a6, 64'h11831985a6, 64'h1165261, 64'h1165126308,
    64'h1965906026, 64'h1598582526328,
    64'h123ba65, 64'h1b08b20a65, 64'h101923b5a6, 64'h15a61929b298b, 64'h163b653513,
    64'h108b0b50515b6, 64'h13b6036065059, 64'h165969bb98,
    64'h15a6478, 64'h143047365a, 64'h11905a6847, 64'h1a65197173794, 64'h1612651478,
    64'h1125526304347, 64'h1847905065026, 64'h1739794329596269,
    64'h13b2784a65, 64'h15a647242027b, 64'h101947823b5a6, 64'h19219b294b7b45a6,
    64'h18473b53515b6, 64'h151b5b610b7b404b, 64'h1059065036b63847, 64'h165969b4797b9,
    64'h1a4964a, 64'h14a649a083, 64'h1a01a60640, 64'h183181686461a, 64'h1149124264,
    64'h1308129249264, 64'h1024426, 64'h1832824426,
    64'h1a49a64b23, 64'h108228b49a4a6, 64'h13b201606461a, 64'h164161a48121b8b1,
    64'h1964936913b63, 64'h18b1810b61914641, 64'h13b6360064, 64'h1648b68,
    64'h17a678a89a, 64'h10730a709a67a, 64'h1a671a7178180, 64'h1a67a71173,
    64'h1126168189867, 64'h1269291679093739, 64'h1780706602, 64'h1732672,
    64'h123ba68a89867, 64'h120727b09767a9a7, 64'h11801781a767a23b, 64'h1b21b17a61671,
    64'h1896867916b63136, 64'h1091b67, 64'h17807063b0b60, 64'h17b6,
    64'h176b, 64'h1308b76, 64'h1019b76, 64'h1819831b76, 64'h1a126b7, 64'h112a3086b7,
    64'h12902a96b7, 64'h16b72a3a83a98,
    64'h1723627, 64'h1708760620, 64'h1276237019, 64'h1162186198876, 64'h1a76a17137,
    64'h1a7617a187108, 64'h103707a0a96a7, 64'h176a7a88a9,
    64'h1684b86, 64'h136b306046, 64'h186b846901, 64'h1946963931b36, 64'h16846b82a1,
    64'h112a30b06b046, 64'h14b846b0292a9, 64'h1a93a32943b36463,
    64'h1823842462, 64'h1042462, 64'h1190234246438, 64'h1194142246, 64'h18138618466a1,
    64'h1a10a06604, 64'h14634386a3039a93, 64'h1a946a4,
    64'h149576b, 64'h1083495b76, 64'h150154076b, 64'h1b76834354315, 64'h1954a1276b,
    64'h16b712a083495, 64'h176b54a42a402, 64'h1348354325a52b76,
    64'h1723762549, 64'h1954086062687, 64'h1362376150540, 64'h1628687218485158,
    64'h1954a16176137, 64'h116a176107870954, 64'h140a4a503a6a737a, 64'h176a7a854a48a,
    64'h16956b9b89, 64'h136b063056095, 64'h10b805b01556b, 64'h16b3635531,
    64'h112a95b9b8b56, 64'h10b306b09656912a, 64'h1b85b56805a52025, 64'h16b36352a3a53,
    64'h1589528562382, 64'h1956960062, 64'h1158180568382628, 64'h1156216,
    64'h113616a386569896, 64'h1a10a06950560, 64'h103856a, 64'h1a56,
    64'h1b5a75b, 64'h1b5ab75830, 64'h15b75ab190, 64'h1a75ab7981831, 64'h1b12b17751,
    64'h108312717572b, 64'h19759279022b7, 64'h175272b592328982,
    64'h125a235375, 64'h1820852875a25, 64'h19015a35373a2, 64'h1982921872a25752,
    64'h1135375, 64'h1087071175, 64'h1903935537, 64'h1987597,
    64'h15845a8ab8, 64'h15045b05abb30, 64'h101984a8aba45, 64'h1ab4a45b34941314,
    64'h12512852b8458, 64'h104b0b345b2b151b, 64'h10250592b5458b85, 64'h19452b3,
    64'h125a352345384, 64'h15a2524420, 64'h13a235a385458019, 64'h15a2524192942,
    64'h1845853351, 64'h1045105, 64'h1845853905035, 64'h1945,
    64'h14b749b9ab, 64'h10834979b79ab, 64'h11ab1b414074b, 64'h13143481a474bab4,
    64'h14b79b492b912, 64'h19749b791b2b1083, 64'h1b74b42240, 64'h1b74b42834324,
    64'h129a279237749, 64'h19a7974a27870207, 64'h137a3a274a1a040a, 64'h11a2874,
    64'h1491417713, 64'h1491417081871, 64'h1403743, 64'h1487,
    64'h19a8ab8, 64'h130939bb9a, 64'h101a0a88ab, 64'h131ab3a, 64'h112b1b99b8,
    64'h130939b1292b9, 64'h102b80b, 64'h132b,
    64'h123828aa89, 64'h19a2092, 64'h123828a0181a8, 64'h11a2, 64'h1138918, 64'h1091,
    64'h1038, 64'h1
  };

endpackage

[rtl/core/marching_cubes_cell_triangulator.sv]
// Marching-cubes cell triangulator: case classification, triangle issue and vertex placement.
// Path to out_: cell slot, issue register, distance and divider stages, output register.
// Throughput: one triangle per cycle while the output is not stalled; a cell holds the input
// until its last triangle (one to five) is issued, and cells without triangles never hold it.
// The edge divider is a restoring divider of FRAC_BITS + 1 pipelined steps, one bit each.
// Reset (rst_n low, synchronous) empties the pipeline and sets surface_level 0, linear_mode 1.
module marching_cubes_cell_triangulator #(
  parameter int GRID_SIZE = 256,
  parameter int FRAC_BITS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mc_tri_pkg::mc_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output mc_tri_pkg::mc_out_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data
);
  import mc_tri_pkg::*;

  localparam int VW = 17;                 // magnitude of a 16-bit difference
  localparam int NW = VW + FRAC_BITS + 2; // dividend and shifted divisor
  localparam int CW = FRAC_BITS + 10;     // signed coordinate before clamping
  localparam int DS = FRAC_BITS + 2;      // abs stage plus one stage per quotient bit
  localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS + 1)'(1) << FRAC_BITS;
  localparam logic [8:0] CELL_MAX = 9'(GRID_SIZE - 2);

  typedef struct packed {
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] z;
    logic [7:0] cube;
    logic       last;
  } sb_t;

  typedef struct packed {
    logic [3:0]         edg;
    logic signed [15:0] va;
    logic signed [15:0] vb;
  } s1_lane_t;

  typedef struct packed {
    logic [3:0]          edg;
    logic [VW-1:0]       ad;
    logic [NW-1:0]       rem;
    logic [FRAC_BITS:0]  q;
  } dv_lane_t;

  // Configuration registers.
  logic signed [15:0] level_r;
  logic               linear_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r  <= '0;
      linear_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SURFACE_LEVEL: level_r  <= cfg_data;
        CFG_LINEAR_MODE:   linear_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Pipeline advance: everything moves when the output register can take an item.
  logic out_valid_r;
  logic adv;
  assign adv = !out_valid_r || !out_stall;

  // Cell slot: holds one classified cell while its triangles are issued.
  logic               slot_v_r;
  logic [63:0]        slot_e_r;
  logic [2:0]         slot_n_r;
  logic [2:0]         slot_t_r;
  sb_t                slot_sb_r;
  logic signed [15:0] slot_val_r [8];

  logic               slot_last;
  logic               in_acc;
  logic [7:0]         cube_in;
  logic [63:0]        ent_in;
  logic [2:0]         n_in;
  logic               keep_in;
  logic signed [15:0] val_in [8];

  assign slot_last = (slot_t_r == 3'(slot_n_r - 3'd1));
  assign in_stall  = slot_v_r && !(adv && slot_last);
  assign in_acc    = in_valid && !in_stall;

  // Classify the incoming cell and look up its triangle list.
  always_comb begin
    val_in[0] = in_data.value_c0;
    val_in[1] = in_data.value_c1;
    val_in[2] = in_data.value_c2;
    val_in[3] = in_data.value_c3;
    val_in[4] = in_data.value_c4;
    val_in[5] = in_data.value_c5;
    val_in[6] = in_data.value_c6;
    val_in[7] = in_data.value_c7;
    for (int i = 0; i < 8; i++) begin
      cube_in[i] = (val_in[i] < level_r);
    end
    ent_in  = TRI_TBL[cube_in];
    n_in    = tri_count(ent_in);
    keep_in = (n_in != 3'd0) &&
              ({1'b0, in_data.cell_x} <= CELL_MAX) &&
              ({1'b0, in_data.cell_y} <= CELL_MAX) &&
              ({1'b0, in_data.cell_z} <= CELL_MAX);
  end

  // A new cell replaces the slot contents; otherwise the slot steps to its next triangle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_v_r <= 1'b0;
      slot_t_r <= '0;
    end else if (in_acc) begin
      slot_v_r <= keep_in;
      slot_t_r <= '0;
    end else if (adv && slot_v_r) begin
      slot_t_r <= slot_t_r + 3'd1;
      if (slot_last) slot_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      slot_e_r     <= ent_in;
      slot_n_r     <= n_in;
      slot_sb_r    <= '{x: in_data.cell_x, y: in_data.cell_y, z: in_data.cell_z,
                        cube: cube_in, last: 1'b0};
      for (int i = 0; i < 8; i++) slot_val_r[i] <= val_in[i];
    end
  end

  // Issue stage: pick the current triangle's edges, one per lane, and their corner values.
  logic [2:0]  tri_idx;
  logic [11:0] tri_edges;
  s1_lane_t    s1_nxt [3];
  sb_t         s1_sb_nxt;
  s1_lane_t    s1_lane_r [3];
  sb_t         s1_sb_r;
  logic        s1_v_r;

  always_comb begin
    tri_idx   = 3'(slot_n_r - 3'd1 - slot_t_r);
    tri_edges = slot_e_r[12*tri_idx +: 12];
    for (int l = 0; l < 3; l++) begin
      s1_nxt[l].edg = tri_edges[4*(2-l) +: 4];
      s1_nxt[l].va  = slot_val_r[edge_corner_a(s1_nxt[l].edg)];
      s1_nxt[l].vb  = slot_val_r[edge_corner_b(s1_nxt[l].edg)];
    end
    s1_sb_nxt      = slot_sb_r;
    s1_sb_nxt.last = slot_last;
  end

  // Distance stage: magnitudes of level - va and vb - va, and the divider's start values.
  dv_lane_t dv_nxt [DS][3];
  dv_lane_t dv_lane_r [DS][3];
  sb_t      dv_sb_r [DS];
  logic     dv_v_r [DS];

  always_comb begin
    logic signed [VW-1:0] n;
    logic signed [VW-1:0] d;
    logic [VW-1:0]        an;
    logic [NW-1:0]        sh;
    for (int l = 0; l < 3; l++) begin
      n  = VW'(level_r) - VW'(s1_lane_r[l].va);
      d  = VW'(s1_lane_r[l].vb) - VW'(s1_lane_r[l].va);
      an = n[VW-1] ? VW'(-n) : VW'(n);
      dv_nxt[0][l].edg = s1_lane_r[l].edg;
      dv_nxt[0][l].ad  = d[VW-1] ? VW'(-d) : VW'(d);
      dv_nxt[0][l].rem = (NW'(an) << (FRAC_BITS + 1)) + NW'(dv_nxt[0][l].ad);
      dv_nxt[0][l].q   = '0;
    end
    // One restoring step per stage, most significant quotient bit first.
    for (int k = 1; k < DS; k++) begin
      for (int l = 0; l < 3; l++) begin
        dv_nxt[k][l] = dv_lane_r[k-1][l];
        sh = NW'({dv_lane_r[k-1][l].ad, 1'b0}) << (FRAC_BITS + 1 - k);
        if (dv_lane_r[k-1][l].rem >= sh) begin
          dv_nxt[k][l].rem = dv_lane_r[k-1][l].rem - sh;
          dv_nxt[k][l].q[FRAC_BITS + 1 - k] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      for (int k = 0; k < DS; k++) dv_v_r[k] <= 1'b0;
    end else if (adv) begin
      s1_v_r    <= slot_v_r;
      dv_v_r[0] <= s1_v_r;
      for (int k = 1; k < DS; k++) dv_v_r[k] <= dv_v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_sb_r    <= s1_sb_nxt;
      dv_sb_r[0] <= s1_sb_r;
      for (int k = 1; k < DS; k++) dv_sb_r[k] <= dv_sb_r[k-1];
      for (int l = 0; l < 3; l++) begin
        s1_lane_r[l] <= s1_nxt[l];
        for (int k = 0; k < DS; k++) dv_lane_r[k][l] <= dv_nxt[k][l];
      end
    end
  end

  // Placement stage: offset along the edge, add to the corner position, clamp.
  mc_out_t out_nxt;
  mc_out_t out_data_r;

  always_comb begin
    logic [FRAC_BITS:0]   off;
    logic [2:0]           pa;
    logic [2:0]           pb;
    logic [7:0]           cidx [3];
    logic [15:0]          crd [3][3];
    logic signed [CW-1:0] c;
    cidx[0] = dv_sb_r[DS-1].x;
    cidx[1] = dv_sb_r[DS-1].y;
    cidx[2] = dv_sb_r[DS-1].z;
    for (int l = 0; l < 3; l++) begin
      if (!linear_r) begin
        off = ONE >> 1;
      end else if (dv_lane_r[DS-1][l].ad == '0) begin
        off = '0;
      end else if (dv_lane_r[DS-1][l].q > ONE) begin
        off = ONE;
      end else begin
        off = dv_lane_r[DS-1][l].q;
      end
      pa = corner_pos(edge_corner_a(dv_lane_r[DS-1][l].edg));
      pb = corner_pos(edge_corner_b(dv_lane_r[DS-1][l].edg));
      for (int a = 0; a < 3; a++) begin
        c = (CW'(cidx[a]) + CW'(pa[2-a])) << FRAC_BITS;
        if (pb[2-a] && !pa[2-a]) c = c + CW'(off);
        else if (pa[2-a] && !pb[2-a]) c = c - CW'(off);
        if (c > CW'(65535)) crd[l][a] = 16'hffff;
        else if (c < 0) crd[l][a] = '0;
        else crd[l][a] = c[15:0];
      end
    end
    out_nxt.p0_x          = crd[0][0];
    out_nxt.p0_y          = crd[0][1];
    out_nxt.p0_z          = crd[0][2];
    out_nxt.p1_x          = crd[1][0];
    out_nxt.p1_y          = crd[1][1];
    out_nxt.p1_z          = crd[1][2];
    out_nxt.p2_x          = crd[2][0];
    out_nxt.p2_y          = crd[2][1];
    out_nxt.p2_z          = crd[2][2];
    out_nxt.cube_case     = dv_sb_r[DS-1].cube;
    out_nxt.last_triangle = dv_sb_r[DS-1].last;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv_v_r[DS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) out_data_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[test/marching_cubes_cell_triangulator_tb.sv]
// Self-checking testbench for the marching-cubes cell triangulator, with driver, monitor and predictor.
`timescale 1ns / 100ps

module marching_cubes_cell_triangulator_tb;
  import mc_tri_pkg::*;

  localparam int FRAC = 8;
  localparam int ONE = 1 << FRAC;
  localparam int DRAIN_CYCLES = FRAC + 20;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  mc_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  mc_out_t out_data;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_SURFACE_LEVEL;
  logic [15:0] cfg_data = '0;

  // Predictor copy of the registers.
  logic signed [15:0] iso_level = 16'sd0;
  logic lerp_on = 1'b1;

  mc_in_t cell_queue[$];
  mc_out_t triangle_queue[$];
  int mismatch_count = 0;
  int triangles_seen = 0;
  int cells_sent = 0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_phase = 0;
  bit sender_hold = 1'b0;

  marching_cubes_cell_triangulator dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic signed [15:0] corner_value(mc_in_t c, int k);
    logic [127:0] v;
    v = c[127:0];
    return v[16*(7-k) +: 16];
  endfunction

  // Vertex on one cube edge, as {x, y, z}.
  function automatic logic [47:0] edge_vertex(mc_in_t c, int edg);
    int ca, cb, k, pa, pb;
    longint n, d, q, off, pos;
    logic [47:0] r;
    logic [7:0] idx [3];
    logic [2:0] pos_a;
    logic [2:0] pos_b;
    ca = int'(edge_corner_a(4'(edg)));
    cb = int'(edge_corner_b(4'(edg)));
    pos_a = corner_pos(3'(ca));
    pos_b = corner_pos(3'(cb));
    idx[0] = c.cell_x;
    idx[1] = c.cell_y;
    idx[2] = c.cell_z;
    if (lerp_on) begin
      n = longint'(iso_level) - longint'(corner_value(c, ca));
      d = longint'(corner_value(c, cb)) - longint'(corner_value(c, ca));
      if (n < 0) n = -n;
      if (d < 0) d = -d;
      if (d == 0) begin
        off = 0;
      end else begin
        q = ((n << (FRAC + 1)) + d) / (2 * d);
        off = (q > ONE) ? ONE : q;
      end
    end else begin
      off = ONE / 2;
    end
    for (k = 0; k < 3; k++) begin
      pa = int'(pos_a[2-k]);
      pb = int'(pos_b[2-k]);
      pos = (longint'(idx[k]) + pa) * ONE;
      if (pb > pa) pos += off;
      else if (pb < pa) pos -= off;
      if (pos > 65535) pos = 65535;
      if (pos < 0) pos = 0;
      r[16*(2-k) +: 16] = 16'(pos);
    end
    return r;
  endfunction

  // Triangles of one cell, appended to the expectation store.
  function automatic void predict_triangles(mc_in_t c);
    logic [7:0] cube;
    logic [63:0] ent;
    int tris, t, v;
    mc_out_t tri_out;
    logic [143:0] verts;
    if (c.cell_x > 8'd254 || c.cell_y > 8'd254 || c.cell_z > 8'd254) return;
    cube = '0;
    for (int k = 0; k < 8; k++) begin
      if (corner_value(c, k) < iso_level) cube[k] = 1'b1;
    end
    if (cube == 8'd0 || cube == 8'd255) return;
    ent = TRI_TBL[cube];
    tris = 0;
    for (int k = 5; k >= 1; k--) begin
      if (tris == 0 && (ent >> (12 * k)) == 64'd1) tris = k;
    end
    for (t = 0; t < tris; t++) begin
      for (v = 0; v < 3; v++) begin
        verts[48*(2-v) +: 48] = edge_vertex(c, int'(ent[12*(tris-1-t) + 4*(2-v) +: 4]));
      end
      tri_out = '0;
      {tri_out.p0_x, tri_out.p0_y, tri_out.p0_z, tri_out.p1_x, tri_out.p1_y,
       tri_out.p1_z, tri_out.p2_x, tri_out.p2_y, tri_out.p2_z} = verts;
      tri_out.cube_case = cube;
      tri_out.last_triangle = (t + 1 == tris);
      triangle_queue = {triangle_queue, tri_out};
    end
  endfunction

  // Driver: bursts of items with random gaps; a stalled item is held.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && in_stall) begin
      in_valid <= 1'b1;
    end else if (sender_hold) begin
      in_valid <= 1'b0;
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      in_valid <= 1'b0;
    end else if (cell_queue.size() > 0) begin
      in_data <= cell_queue.pop_front();
      in_valid <= 1'b1;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 20);
        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver stall pattern: quiet windows alternating with random stalls.
  always @(negedge clk) begin
    stall_phase <= (stall_phase + 1) % 96;
    if (stall_phase < 32) out_stall <= 1'b0;
    else if (stall_phase < 64) out_stall <= ($urandom_range(0, 3) == 0);
    else out_stall <= ($urandom_range(0, 1) == 0);
  end

  // Prediction on accepted items.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      predict_triangles(in_data);
      cells_sent <= cells_sent + 1;
    end
  end

  // Monitor: compare each accepted triangle with the oldest expectation.
  always @(posedge clk) begin
    mc_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      triangles_seen <= triangles_seen + 1;
      if (triangle_queue.size() == 0) begin
        mismatch_count <= mismatch_count + 1;
        if (mismatch_count < 10) $display("Unexpected triangle %h", out_data);
      end else begin
        want = triangle_queue.pop_front();
        if (out_data !== want) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < 10) begin
            $display("Triangle mismatch: expected %h, got %h", want, out_data);
          end
        end
      end
    end
  end

  function automatic mc_in_t random_cell(int mode);
    mc_in_t c;
    logic [127:0] v;
    c.cell_x = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(250, 255))
                                          : 8'($urandom_range(0, 255));
    c.cell_y = 8'($urandom_range(0, 255));
    c.cell_z = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 4) != 0) begin
      c.cell_y = 8'($urandom_range(0, 254));
      c.cell_z = 8'($urandom_range(0, 254));
      if (c.cell_x == 8'd255) c.cell_x = 8'd254;
    end
    for (int k = 0; k < 8; k++) begin
      if (mode == 0) v[16*k +: 16] = 16'($urandom());
      else v[16*k +: 16] = 16'(int'(iso_level) + $urandom_range(0, 2000) - 1000);
    end
    c[127:0] = v;
    return c;
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_SURFACE_LEVEL) iso_level = val;
    else if (idx == CFG_LINEAR_MODE) lerp_on = val[0];
  endtask

  task automatic wait_idle();
    while (cell_queue.size() > 0 || in_valid || triangle_queue.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    mc_in_t c;
    logic [15:0] levels [5];
    levels = '{16'h0000, 16'h8000, 16'h7fff, 16'h1000, 16'hf000};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed cells: each single-corner case, extremes, equal corners, out of grid.
    for (int k = 0; k < 8; k++) begin
      c = '0;
      c.cell_x = 8'(k * 36);
      c.cell_y = 8'd254;
      c.cell_z = 8'(k);
      c[127:0] = {8{16'h7fff}};
      c[16*(7-k) +: 16] = 16'h8000;
      cell_queue = {cell_queue, c};
    end
    c = '0;
    c[127:0] = {8{16'h8000}};
    cell_queue = {cell_queue, c};
    c[127:0] = {16'h8000, 16'h0000, 16'h7fff, 16'hffff, 16'h8000, 16'h0001, 16'h0000, 16'hffff};
    cell_queue = {cell_queue, c};
    c.cell_x = 8'd255;
    cell_queue = {cell_queue, c};
    c.cell_x = 8'd0;
    c.cell_z = 8'd255;
    cell_queue = {cell_queue, c};
    c = '0;
    c.cell_x = 8'd254;
    c.cell_z = 8'd254;
    c[127:0] = {16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff};
    cell_queue = {cell_queue, c};
    for (int k = 0; k < 6; k++) cell_queue = {cell_queue, random_cell(1)};
    wait_idle();

    // Random cells across several register settings, extremes included.
    for (int p = 0; p < 10; p++) begin
      write_reg(CFG_SURFACE_LEVEL, (p < 5) ? levels[p] : 16'($urandom()));
      write_reg(CFG_LINEAR_MODE, 16'((p % 3) != 1));
      write_reg(2'd3, 16'($urandom()));
      for (int k = 0; k < 35; k++) begin
        cell_queue = {cell_queue, random_cell($urandom_range(0, 3) != 0)};
      end
      if (p == 4) begin
        while (cell_queue.size() > 20) @(posedge clk);
        sender_hold = 1'b1;
        while (in_valid || triangle_queue.size() > 0) @(posedge clk);
        sender_hold = 1'b0;
      end
      wait_idle();
    end

    $display("Sent %0d cells and checked %0d triangles over ten register settings.",
             cells_sent, triangles_seen);
    if (mismatch_count == 0 && triangle_queue.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

[marching_cubes_cell_triangulator.f]
rtl/core/mc_tri_pkg.sv
rtl/core/marching_cubes_cell_triangulator.sv
test/marching_cubes_cell_triangulator_tb.sv
